>>> rtl/bitmap_horizontal_span_fill_macros.svh
// Assertion macros shared by the span fill RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef BITMAP_HORIZONTAL_SPAN_FILL_MACROS_SVH
`define BITMAP_HORIZONTAL_SPAN_FILL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BHSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BHSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/bhsf_pkg.sv
package bhsf_pkg;

  localparam int STORE_BYTES_DFLT   = 1024;
  localparam int MAX_ROW_BYTES_DFLT = 64;

  localparam int CMD_W    = 1;
  localparam int X_W      = 9;
  localparam int ROW_W    = 10;
  localparam int BADDR_W  = 10;
  localparam int RB_W     = 7;
  localparam int BYTE_W   = 8;
  // Row head address is row * row_bytes; a span address adds a byte column.
  localparam int HEAD_W   = ROW_W + RB_W;
  localparam int SUM_W    = HEAD_W + 1;

  localparam logic [RB_W-1:0]   ROW_BYTES_RST = 7'd16;
  localparam logic [BYTE_W-1:0] BYTE_FULL     = 8'hFF;

  localparam logic [CMD_W-1:0] CMD_DRAW = 1'b0;
  localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

  // Decoded span of one draw command.
  typedef struct packed {
    logic              err;
    logic [SUM_W-1:0]  first;
    logic [SUM_W-1:0]  last;
    logic [BYTE_W-1:0] lead;
    logic [BYTE_W-1:0] tail;
  } span_t;

endpackage

>>> rtl/bhsf_ram.sv
module bhsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/bhsf_span_calc.sv
module bhsf_span_calc import bhsf_pkg::*; #(
  parameter int STORE_BYTES   = STORE_BYTES_DFLT,
  parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DFLT
) (
  input  logic [RB_W-1:0]   row_bytes_i,
  input  logic [HEAD_W-1:0] head_i,
  input  logic [X_W-1:0]    x_start_i,
  input  logic [X_W-1:0]    x_end_i,
  output span_t             span_o
);

  logic             bad_width;
  logic             reversed;
  logic             past_row;
  logic             bad_row;
  logic [SUM_W-1:0] row_end;

  // The row fits when its end, head plus one row, stays within the store.
  assign row_end   = SUM_W'(head_i) + SUM_W'(row_bytes_i);
  assign bad_width = (row_bytes_i == '0) || (32'(row_bytes_i) > 32'(MAX_ROW_BYTES));
  assign reversed  = x_start_i > x_end_i;
  assign past_row  = {1'b0, x_end_i} >= {row_bytes_i, 3'b000};
  assign bad_row   = 32'(row_end) > 32'(STORE_BYTES);

  always_comb begin
    span_o.err   = bad_width || reversed || past_row || bad_row;
    span_o.first = SUM_W'(head_i) + SUM_W'(x_start_i[X_W-1:3]);
    span_o.last  = SUM_W'(head_i) + SUM_W'(x_end_i[X_W-1:3]);
    span_o.lead  = BYTE_FULL >> x_start_i[2:0];
    span_o.tail  = BYTE_W'(BYTE_FULL << (3'd7 - x_end_i[2:0]));
  end

endmodule

>>> rtl/bitmap_horizontal_span_fill.sv
// A read issues the store read, then returns the byte; a draw multiplies, decodes,
// then makes one frame store write per byte; errors end early.
// The block takes one command at a time; the next one is taken at the edge ending the result.
// Reset clears the control state and row_bytes to 16, then a clearing pass writes zero
// to every store byte with busy high. Results cannot be stalled.
`include "bitmap_horizontal_span_fill_macros.svh"

module bitmap_horizontal_span_fill import bhsf_pkg::*; #(
  parameter int STORE_BYTES   = STORE_BYTES_DFLT,
  parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DFLT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Command channel.
  input  logic               start,
  output logic               busy,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [X_W-1:0]     x_start_i,
  input  logic [X_W-1:0]     x_end_i,
  input  logic [ROW_W-1:0]   row_i,
  input  logic [BADDR_W-1:0] byte_address_i,
  // Result, shown for one cycle while done_o is high.
  output logic               done_o,
  output logic [BYTE_W-1:0]  read_byte_o,
  output logic               status_o,
  // Configuration write channel for row_bytes.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [RB_W-1:0]    cfg_row_bytes_i
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

  // The whole frame sits in one RAM. Each command walks a short sequence:
  // a read issues one RAM read; a draw multiplies out the row head, decodes
  // the span, then read-modify-writes the first byte and, for a wider span,
  // fills the middle bytes with all ones and read-modify-writes the last byte.
  // No byte of a command is read after it is written, and a command starts
  // only after the last write of the previous one, so no forwarding is needed.
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_ISSUE,
    S_RD_DATA,
    S_MUL,
    S_EVAL,
    S_FIRST,
    S_FILL,
    S_LAST
  } state_e;

  state_e              state_q, state_d;
  logic [CMD_W-1:0]    cmd_q, cmd_d;
  logic [X_W-1:0]      xs_q, xs_d;
  logic [X_W-1:0]      xe_q, xe_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [BADDR_W-1:0]  baddr_q, baddr_d;
  logic [HEAD_W-1:0]   head_q, head_d;
  logic [AW-1:0]       cur_q, cur_d;
  logic [AW-1:0]       first_q, first_d;
  logic [AW-1:0]       last_q, last_d;
  logic [BYTE_W-1:0]   lead_q, lead_d;
  logic [BYTE_W-1:0]   tail_q, tail_d;
  logic                single_q, single_d;
  logic                done_q, done_d;
  logic [BYTE_W-1:0]   rbyte_q, rbyte_d;
  logic                status_q, status_d;
  logic [RB_W-1:0]     row_bytes_q;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [BYTE_W-1:0]   ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [BYTE_W-1:0]   ram_rdata;
  logic                addr_ok;
  span_t               span;

  assign busy        = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign read_byte_o = rbyte_q;
  assign status_o    = status_q;
  assign addr_ok     = 32'(baddr_q) < 32'(STORE_BYTES);

  // The user must change the register only while idle; the block does not enforce it and takes it as is.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q <= ROW_BYTES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      row_bytes_q <= cfg_row_bytes_i;
    end
  end

  bhsf_span_calc #(
    .STORE_BYTES  (STORE_BYTES),
    .MAX_ROW_BYTES(MAX_ROW_BYTES)
  ) u_span_calc (
    .row_bytes_i(row_bytes_q),
    .head_i     (head_q),
    .x_start_i  (xs_q),
    .x_end_i    (xe_q),
    .span_o     (span)
  );

  bhsf_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(STORE_BYTES)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    xs_d      = xs_q;
    xe_d      = xe_q;
    row_d     = row_q;
    baddr_d   = baddr_q;
    head_d    = head_q;
    cur_d     = cur_q;
    first_d   = first_q;
    last_d    = last_q;
    lead_d    = lead_q;
    tail_d    = tail_q;
    single_d  = single_q;
    done_d    = 1'b0;
    rbyte_d   = rbyte_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = cur_q;
    ram_wdata = '0;
    ram_raddr = cur_q;

    case (state_q)
      S_CLEAR: begin
        // Zero one byte per cycle after reset.
        ram_we    = 1'b1;
        ram_waddr = cur_q;
        ram_wdata = '0;
        if (cur_q == LAST_ADDR) begin
          cur_d   = '0;
          state_d = S_IDLE;
        end else begin
          cur_d = cur_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_d   = command_i;
          xs_d    = x_start_i;
          xe_d    = x_end_i;
          row_d   = row_i;
          baddr_d = byte_address_i;
          state_d = (command_i == CMD_READ) ? S_RD_ISSUE : S_MUL;
        end
      end
      S_RD_ISSUE: begin
        ram_raddr = AW'(baddr_q);
        if (addr_ok) begin
          state_d = S_RD_DATA;
        end else begin
          done_d   = 1'b1;
          rbyte_d  = '0;
          status_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_RD_DATA: begin
        done_d   = 1'b1;
        rbyte_d  = ram_rdata;
        status_d = 1'b0;
        state_d  = S_IDLE;
      end
      S_MUL: begin
        head_d  = HEAD_W'(row_q) * HEAD_W'(row_bytes_q);
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (span.err) begin
          done_d   = 1'b1;
          rbyte_d  = '0;
          status_d = 1'b1;
          state_d  = S_IDLE;
        end else begin
          ram_raddr = AW'(span.first);
          first_d   = AW'(span.first);
          last_d    = AW'(span.last);
          cur_d     = AW'(span.first) + AW'(1);
          lead_d    = span.lead;
          tail_d    = span.tail;
          single_d  = span.first == span.last;
          state_d   = S_FIRST;
        end
      end
      S_FIRST: begin
        ram_we    = 1'b1;
        ram_waddr = first_q;
        ram_wdata = ram_rdata | (single_q ? (lead_q & tail_q) : lead_q);
        if (single_q) begin
          done_d   = 1'b1;
          rbyte_d  = '0;
          status_d = 1'b0;
          state_d  = S_IDLE;
        end else if (cur_q == last_q) begin
          ram_raddr = last_q;
          state_d   = S_LAST;
        end else begin
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cur_q;
        ram_wdata = BYTE_FULL;
        cur_d     = cur_q + AW'(1);
        if ((cur_q + AW'(1)) == last_q) begin
          ram_raddr = last_q;
          state_d   = S_LAST;
        end
      end
      S_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = last_q;
        ram_wdata = ram_rdata | tail_q;
        done_d    = 1'b1;
        rbyte_d   = '0;
        status_d  = 1'b0;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      cmd_q    <= CMD_DRAW;
      xs_q     <= '0;
      xe_q     <= '0;
      row_q    <= '0;
      baddr_q  <= '0;
      head_q   <= '0;
      cur_q    <= '0;
      first_q  <= '0;
      last_q   <= '0;
      lead_q   <= '0;
      tail_q   <= '0;
      single_q <= 1'b0;
      done_q   <= 1'b0;
      rbyte_q  <= '0;
      status_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cmd_q    <= cmd_d;
      xs_q     <= xs_d;
      xe_q     <= xe_d;
      row_q    <= row_d;
      baddr_q  <= baddr_d;
      head_q   <= head_d;
      cur_q    <= cur_d;
      first_q  <= first_d;
      last_q   <= last_d;
      lead_q   <= lead_d;
      tail_q   <= tail_d;
      single_q <= single_d;
      done_q   <= done_d;
      rbyte_q  <= rbyte_d;
      status_q <= status_d;
    end
  end

  // A result beat always closes a command that kept the block busy.
  `BHSF_ASSERT_NOW(a_done_after_busy, done_o, $past(busy), "result beat without a command")
  // The middle fill never overwrites the last byte, which still needs its merge.
  `BHSF_ASSERT_NOW(a_fill_below_last, state_q == S_FILL, ram_waddr != last_q, "fill hit last byte")
  // A draw never returns store data.
  `BHSF_ASSERT_NOW(a_draw_zero_byte, done_o && (cmd_q == CMD_DRAW), read_byte_o == '0, "draw returned data")
  // A rejected span leaves the store untouched.
  `BHSF_ASSERT_NEXT(a_err_no_write, (state_q == S_EVAL) && span.err, !ram_we, "write after bad span")

endmodule
